[rtl/core/msp_pkg.sv]
// Shared types and constants for the multichannel servo PWM core.
// No dependencies; imported by every module of the block.
package msp_pkg;

    // Transaction modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_CHANGE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CYCLE_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_MAX_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_MIN_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_CYCLE_LENGTH  = 16'd20000;
    localparam logic [11:0] RST_MAX_THRESHOLD = 12'd3000;
    localparam logic [11:0] RST_MIN_THRESHOLD = 12'd0;

    // Channels visible on the level output
    localparam int LEVEL_BITS = 8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  pin;
        logic [11:0] threshold;
    } t_item;

    typedef struct packed {
        logic [7:0]  channel_levels;
        logic        ok;
        logic [11:0] read_threshold;
        logic [3:0]  channel_count;
        logic        cycle_start;
    } t_result;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [15:0] cycle_length;
        logic [11:0] max_threshold;
        logic [11:0] min_threshold;
    } t_cfg;

    // One channel table entry
    typedef struct packed {
        logic [5:0]  pin;
        logic [11:0] width;
    } t_entry;

endpackage

[rtl/core/msp_stream_if.sv]
// Valid/ready channel carrying one payload of a chosen type.
// No dependencies; the payload type is set where the channel is declared.
interface msp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/msp_chan_mem.sv]
// Channel table: synchronous memory of pin and width entries, registered read.
// Depends on msp_pkg for the entry type.
module msp_chan_mem
    import msp_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/msp_scan_ctrl.sv]
// Sequencer: sweeps the channel table per transaction, applies add/change/query,
// advances the period counter and holds the result register.
// Depends on msp_pkg and msp_stream_if; drives the ports of msp_chan_mem.
module msp_scan_ctrl
    import msp_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int IW           = 3,
    parameter int CW           = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    msp_stream_if.sink    i_item,
    msp_stream_if.source  o_result,
    output logic          o_mem_re,
    output logic [IW-1:0] o_mem_raddr,
    output logic          o_mem_we,
    output logic [IW-1:0] o_mem_waddr,
    output t_entry        o_mem_wdata,
    input  t_entry        i_mem_rdata
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]    r_state, n_state;
    t_item         r_item;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_tag;
    logic          r_found;
    logic [IW-1:0] r_match_idx;
    logic [11:0]   r_match_w;
    logic [7:0]    r_levels;
    logic [CW-1:0] r_count;
    logic [15:0]   r_ctr;
    logic          r_out_vld;
    t_result       r_out;

    logic          accept;
    logic          scan_last;
    logic          finish_go;
    logic          add_ok, chg_ok;
    logic          new_lvl;
    logic [IW-1:0] upd_idx;
    logic [7:0]    fin_levels;
    logic [16:0]   ctr_inc;
    t_result       n_out;

    function automatic logic lvl_bit(input logic [15:0] ctr, input logic [11:0] w,
                                     input logic [11:0] max_thr);
        lvl_bit = (ctr < 16'(w)) && (ctr < 16'(max_thr));
    endfunction

    assign accept    = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign scan_last = ((CW'(r_rd_idx) + CW'(1)) == r_count);
    assign finish_go = (r_state == S_FINISH) && (!r_out_vld || o_result.ready);

    // Sequence the table sweep
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = (r_count == '0) ? S_FINISH : S_SCAN;
            S_SCAN:   if (scan_last) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: if (finish_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Issue one table read per sweep cycle
    assign o_mem_re    = (r_state == S_SCAN);
    assign o_mem_raddr = r_rd_idx;

    // Work out the outcome of the held transaction
    assign ctr_inc = {1'b0, r_ctr} + 17'd1;
    assign add_ok  = (r_item.mode == MODE_ADD) && (r_count < CW'(NUM_CHANNELS));
    assign chg_ok  = (r_item.mode == MODE_CHANGE) && r_found
                     && (r_item.threshold >= i_cfg.min_threshold)
                     && (r_item.threshold <= i_cfg.max_threshold);
    assign upd_idx = add_ok ? IW'(r_count) : r_match_idx;
    assign new_lvl = lvl_bit(r_ctr, r_item.threshold, i_cfg.max_threshold);

    always_comb begin
        fin_levels = r_levels;
        if ((add_ok || chg_ok) && ((IW + 3)'(upd_idx) < (IW + 3)'(LEVEL_BITS))) begin
            fin_levels[3'(upd_idx)] = new_lvl;
        end

        n_out                = '0;
        n_out.channel_levels = fin_levels;
        n_out.channel_count  = 4'((CW + 4)'(r_count) + (CW + 4)'(add_ok));
        case (r_item.mode)
            MODE_TICK: begin
                n_out.ok          = 1'b1;
                n_out.cycle_start = (r_ctr == '0);
            end
            MODE_ADD:    n_out.ok = add_ok;
            MODE_CHANGE: n_out.ok = chg_ok;
            MODE_QUERY: begin
                n_out.ok             = r_found;
                n_out.read_threshold = r_found ? r_match_w : 12'd0;
            end
            default: n_out = n_out;
        endcase
    end

    // Write back the added or changed entry
    assign o_mem_we    = finish_go && (add_ok || chg_ok);
    assign o_mem_waddr = upd_idx;
    assign o_mem_wdata = '{pin: r_item.pin, width: r_item.threshold};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_ctr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= o_mem_re;
            if (finish_go) begin
                r_out_vld <= 1'b1;
                if (add_ok) begin
                    r_count <= r_count + CW'(1);
                end
                if (r_item.mode == MODE_TICK) begin
                    r_ctr <= (ctr_inc >= {1'b0, i_cfg.cycle_length}) ? 16'd0 : ctr_inc[15:0];
                end
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload and sweep bookkeeping
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_item.data;
            r_rd_idx <= '0;
            r_found  <= 1'b0;
            r_levels <= '0;
        end else if (r_state == S_SCAN && !scan_last) begin
            r_rd_idx <= r_rd_idx + IW'(1);
        end
        r_rd_tag <= r_rd_idx;
        // Gather levels and the first pin match from returned entries
        if (r_rd_vld) begin
            if ((IW + 3)'(r_rd_tag) < (IW + 3)'(LEVEL_BITS)) begin
                r_levels[3'(r_rd_tag)] <= lvl_bit(r_ctr, i_mem_rdata.width,
                                                  i_cfg.max_threshold);
            end
            if (!r_found && (i_mem_rdata.pin == r_item.pin)) begin
                r_found     <= 1'b1;
                r_match_idx <= r_rd_tag;
                r_match_w   <= i_mem_rdata.width;
            end
        end
        if (finish_go) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

`ifndef NO_ASSERTIONS
    a_we_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_FINISH))
        else $error("table written outside finish");
    a_rd_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_SCAN))
        else $error("read data without a read");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_result.ready) |-> !finish_go)
        else $error("pending result overwritten");
    a_count_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish_go && add_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("channel count not advanced on add");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_CHANNELS))
        else $error("channel count beyond capacity");
`endif

endmodule

[rtl/core/multichannel_servo_pwm_core.sv]
// Multichannel servo PWM core: configuration registers, sequencer and channel table.
// One transaction at a time: after acceptance the sweep reads one table entry per
// cycle through one port in the scan state, then the drain and finish states follow;
// with no defined channels the finish state follows acceptance directly. The result
// is registered in the finish step; a result still held at the output stalls it.
// Reset (synchronous, active low) clears the channel count, period counter and
// control state and restores the configuration defaults; table contents persist.
module multichannel_servo_pwm_core
    import msp_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msp_stream_if.sink   i_item,
    msp_stream_if.source o_result,
    msp_stream_if.sink   i_cfg
);

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = $clog2(NUM_CHANNELS + 1);

    t_cfg          r_cfg;
    t_cfg_wr       cfg_wr;
    logic          mem_re, mem_we;
    logic [IW-1:0] mem_raddr, mem_waddr;
    t_entry        mem_wdata, mem_rdata;

    assign cfg_wr      = i_cfg.data;
    assign i_cfg.ready = 1'b1;

    // Decode configuration writes; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cycle_length  <= RST_CYCLE_LENGTH;
            r_cfg.max_threshold <= RST_MAX_THRESHOLD;
            r_cfg.min_threshold <= RST_MIN_THRESHOLD;
        end else if (i_cfg.valid) begin
            unique case (cfg_wr.index)
                CFG_CYCLE_LENGTH:  r_cfg.cycle_length  <= cfg_wr.value;
                CFG_MAX_THRESHOLD: r_cfg.max_threshold <= cfg_wr.value[11:0];
                CFG_MIN_THRESHOLD: r_cfg.min_threshold <= cfg_wr.value[11:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    msp_scan_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .IW          (IW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (i_item),
        .o_result   (o_result),
        .o_mem_re   (mem_re),
        .o_mem_raddr(mem_raddr),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .i_mem_rdata(mem_rdata)
    );

    msp_chan_mem #(
        .DEPTH(NUM_CHANNELS),
        .IW   (IW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

endmodule

[tb/sv/servo_pwm_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the multichannel servo PWM core: watches the item, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on msp_pkg for the transaction, result and register write types.
module servo_pwm_checker
    import msp_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  logic    i_item_ready,
    input  t_item   i_item_data,
    input  logic    i_res_valid,
    input  logic    i_res_ready,
    input  t_result i_res_data,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_ready,
    input  t_cfg_wr i_cfg_data,
    output int      o_fail_count,
    output int      o_pending
);

    // Shadow of the block's registers and channel table
    t_cfg        cfg_shadow;
    int          chan_count;
    logic [5:0]  pin_tab   [NUM_CHANNELS];
    logic [11:0] width_tab [NUM_CHANNELS];
    logic [15:0] period;

    t_result     servo_results_due [$];
    int          fails;

    // Lowest-numbered defined channel carrying this pin, or -1
    function automatic int find_pin(logic [5:0] pin);
        for (int i = 0; i < chan_count; i++) begin
            if (pin_tab[i] == pin)
                return i;
        end
        return -1;
    endfunction

    // Apply one transaction to the shadow state and return the result it yields
    function automatic t_result predict_servo_result(t_item it);
        t_result r;
        int      idx;
        r = '0;
        case (it.mode)
            MODE_ADD: begin
                if (chan_count < NUM_CHANNELS) begin
                    pin_tab[chan_count]   = it.pin;
                    width_tab[chan_count] = it.threshold;
                    chan_count++;
                    r.ok = 1'b1;
                end
            end
            MODE_CHANGE: begin
                if (it.threshold >= cfg_shadow.min_threshold &&
                    it.threshold <= cfg_shadow.max_threshold) begin
                    idx = find_pin(it.pin);
                    if (idx >= 0) begin
                        width_tab[idx] = it.threshold;
                        r.ok = 1'b1;
                    end
                end
            end
            MODE_QUERY: begin
                idx = find_pin(it.pin);
                if (idx >= 0) begin
                    r.read_threshold = width_tab[idx];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase

        // Levels use the counter before any advance, after the table update
        for (int i = 0; i < chan_count && i < LEVEL_BITS; i++) begin
            if (period < width_tab[i] && period < cfg_shadow.max_threshold)
                r.channel_levels[i] = 1'b1;
        end

        // Advance the period counter, wrapping at the cycle length
        if (it.mode == MODE_TICK) begin
            r.ok = 1'b1;
            r.cycle_start = (period == 16'd0);
            if (int'(period) + 1 >= int'(cfg_shadow.cycle_length))
                period = 16'd0;
            else
                period = period + 16'd1;
        end
        r.channel_count = 4'(chan_count);
        return r;
    endfunction

    // Report one field; returns 1 on a mismatch
    function automatic int check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Track register writes, queue predictions, retire results in order
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            cfg_shadow.cycle_length  = RST_CYCLE_LENGTH;
            cfg_shadow.max_threshold = RST_MAX_THRESHOLD;
            cfg_shadow.min_threshold = RST_MIN_THRESHOLD;
            chan_count = 0;
            period     = 16'd0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                pin_tab[i]   = '0;
                width_tab[i] = '0;
            end
            servo_results_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_CYCLE_LENGTH:  cfg_shadow.cycle_length  = i_cfg_data.value;
                    CFG_MAX_THRESHOLD: cfg_shadow.max_threshold = i_cfg_data.value[11:0];
                    CFG_MIN_THRESHOLD: cfg_shadow.min_threshold = i_cfg_data.value[11:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (servo_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_res_data);
                    fails++;
                end else begin
                    exp_r = servo_results_due.pop_front();
                    fails += check_field("channel_levels", 16'(exp_r.channel_levels),
                                         16'(i_res_data.channel_levels));
                    fails += check_field("ok", 16'(exp_r.ok), 16'(i_res_data.ok));
                    fails += check_field("read_threshold", 16'(exp_r.read_threshold),
                                         16'(i_res_data.read_threshold));
                    fails += check_field("channel_count", 16'(exp_r.channel_count),
                                         16'(i_res_data.channel_count));
                    fails += check_field("cycle_start", 16'(exp_r.cycle_start),
                                         16'(i_res_data.cycle_start));
                end
            end
            if (i_item_valid && i_item_ready)
                servo_results_due.push_back(predict_servo_result(i_item_data));
        end
        o_pending    <= servo_results_due.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the servo PWM core testbench: clock, reset, stimulus and verdict.
// Depends on msp_pkg, msp_stream_if, the core and servo_pwm_checker.
module testbench;
    import msp_pkg::*;

    localparam int         ITEMS_PER_PHASE = 140;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         SETTLE_CYCLES   = 20;
    localparam logic [1:0] CFG_UNUSED      = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    msp_stream_if #(.T(t_item))   item_ch ();
    msp_stream_if #(.T(t_result)) res_ch ();
    msp_stream_if #(.T(t_cfg_wr)) cfg_ch ();

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   settings    = 1;
    bit   quiet       = 1'b0;

    // Register values as last written, for steering thresholds
    int   cur_cycle = RST_CYCLE_LENGTH;
    int   cur_max   = RST_MAX_THRESHOLD;
    int   cur_min   = RST_MIN_THRESHOLD;

    // Pins added by the directed part; the table is full after it
    logic [5:0] table_pins [8] = '{6'd0, 6'd63, 6'd63, 6'd21, 6'd42, 6'd7, 6'd56, 6'd1};

    multichannel_servo_pwm_core #(.NUM_CHANNELS(8)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    servo_pwm_checker #(.NUM_CHANNELS(8)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_ch.valid),
        .i_item_ready (item_ch.ready),
        .i_item_data  (item_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_data   (cfg_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result sink: stall for a random number of cycles after each result taken
    int sink_hold;
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_hold    <= 0;
        end else if (sink_hold > 0) begin
            sink_hold    <= sink_hold - 1;
            res_ch.ready <= (sink_hold == 1);
        end else if (res_ch.valid && res_ch.ready) begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            sink_hold    <= stall;
            res_ch.ready <= (stall == 0);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Send one transaction after a random gap; valid stays high for the next one
    task automatic send_item(input logic [1:0] mode, input logic [5:0] pin,
                             input logic [11:0] thr);
        t_item it;
        int    gap;
        it.mode      = mode;
        it.pin       = pin;
        it.threshold = thr;
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Hold the sender until every result is back and the core has settled
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        t_cfg_wr wr;
        wr.index = idx;
        wr.value = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= wr;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_CYCLE_LENGTH:  cur_cycle = value;
            CFG_MAX_THRESHOLD: cur_max   = value[11:0];
            CFG_MIN_THRESHOLD: cur_min   = value[11:0];
            default: ;
        endcase
    endtask

    // Reprogram all registers while idle; a write to the unused index must be ignored
    task automatic apply_setting(input int cycle_len, input int max_thr, input int min_thr);
        drain_results();
        write_reg(CFG_CYCLE_LENGTH, 16'(cycle_len));
        write_reg(CFG_MAX_THRESHOLD, 16'(max_thr));
        write_reg(CFG_MIN_THRESHOLD, 16'(min_thr));
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    // Mostly ticks and lookups on known pins, thresholds steered near the limits
    task automatic random_item();
        int          sel;
        int          hi;
        logic [1:0]  mode;
        logic [5:0]  pin;
        logic [11:0] thr;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            mode = MODE_TICK;
        else if (sel < 75)
            mode = MODE_CHANGE;
        else if (sel < 90)
            mode = MODE_QUERY;
        else
            mode = MODE_ADD;
        if ($urandom_range(0, 9) < 7)
            pin = table_pins[$urandom_range(0, 7)];
        else
            pin = 6'($urandom_range(0, 63));
        sel = $urandom_range(0, 99);
        if (cur_min <= cur_max && sel < 60) begin
            hi = (cur_max < cur_cycle) ? cur_max : cur_cycle;
            if (hi < cur_min)
                hi = cur_max;
            thr = 12'($urandom_range(cur_min, hi));
        end else if (sel < 75) begin
            case ($urandom_range(0, 3))
                0:       thr = 12'(cur_min);
                1:       thr = 12'(cur_max);
                2:       thr = 12'(cur_min - 1);
                default: thr = 12'(cur_max + 1);
            endcase
        end else begin
            thr = 12'($urandom_range(0, 4095));
        end
        send_item(mode, pin, thr);
    endtask

    task automatic run_phase(input int cycle_len, input int max_thr, input int min_thr);
        apply_setting(cycle_len, max_thr, min_thr);
        repeat (ITEMS_PER_PHASE) random_item();
    endtask

    initial begin
        int mx;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, first ticks, then fill the table past its capacity
        send_item(MODE_QUERY,  6'd0,  12'd0);
        send_item(MODE_CHANGE, 6'd0,  12'd100);
        send_item(MODE_TICK,   6'd0,  12'd0);
        send_item(MODE_TICK,   6'd63, 12'd4095);
        send_item(MODE_ADD,    6'd0,  12'd0);
        send_item(MODE_ADD,    6'd63, 12'd4095);
        send_item(MODE_TICK,   6'd0,  12'd0);
        send_item(MODE_ADD,    6'd63, 12'd5);
        send_item(MODE_ADD,    6'd21, 12'd1);
        send_item(MODE_ADD,    6'd42, 12'd2);
        send_item(MODE_ADD,    6'd7,  12'd3000);
        send_item(MODE_ADD,    6'd56, 12'd3001);
        send_item(MODE_ADD,    6'd1,  12'd2999);
        send_item(MODE_ADD,    6'd9,  12'd10);
        // Boundaries of the change range, duplicate pins, missing pins
        send_item(MODE_CHANGE, 6'd63, 12'd3000);
        send_item(MODE_CHANGE, 6'd63, 12'd3001);
        send_item(MODE_CHANGE, 6'd42, 12'd0);
        send_item(MODE_QUERY,  6'd63, 12'd0);
        send_item(MODE_QUERY,  6'd9,  12'd0);
        send_item(MODE_QUERY,  6'd56, 12'd0);
        repeat (5) send_item(MODE_TICK, 6'd0, 12'd0);

        // Extremes first, then narrow windows; long cycle before short ones forces a wrap
        run_phase(1,     4095, 4095);
        run_phase(65535, 0,    0);
        run_phase(64,    4095, 0);
        run_phase(200,   150,  20);
        run_phase(120,   90,   10);
        run_phase(300,   100,  200);
        mx = $urandom_range(0, 400);
        run_phase($urandom_range(2, 400), mx, $urandom_range(0, mx));
        run_phase(RST_CYCLE_LENGTH, RST_MAX_THRESHOLD, RST_MIN_THRESHOLD);
        drain_results();

        $display("Covered %0d transactions over %0d register settings with random stalls,",
                 items_sent, settings);
        $display("including a full channel table, duplicate pins and counter wrap-around.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/msp_pkg.sv
rtl/core/msp_stream_if.sv
rtl/core/msp_chan_mem.sv
rtl/core/msp_scan_ctrl.sv
rtl/core/multichannel_servo_pwm_core.sv
tb/sv/servo_pwm_checker.sv
tb/sv/testbench.sv
